FILE: rtl/smbpec_pkg.sv
// Shared constants, register indexes and the CRC-8 byte step for the SMBus PEC reader.
package smbpec_pkg;

    localparam int unsigned AddrW    = 7;
    localparam int unsigned RetryW   = 3;
    localparam int unsigned CountW   = 8;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned WordW    = 16;
    localparam int unsigned TempW    = 18;
    localparam int unsigned CfgIdxW  = 2;

    localparam logic [ByteW-1:0]  CrcPoly      = 8'h07;
    localparam logic [ByteW-1:0]  CrcInit      = 8'h00;
    localparam logic [AddrW-1:0]  RstDevAddr   = 7'h5A;
    localparam logic [RetryW-1:0] RstRetry     = 3'd3;
    localparam logic [CountW-1:0] RstThreshold = 8'd5;
    localparam logic [CountW-1:0] FailSat      = 8'hFF;
    localparam logic signed [TempW-1:0] TempOffset = 18'sd27315;

    localparam logic [CfgIdxW-1:0] CfgDevAddr   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRetry     = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd2;

    function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc_in,
                                                   input logic [ByteW-1:0] data);
        logic [ByteW-1:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < ByteW; k++) begin
            if (c[ByteW-1]) begin
                c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[ByteW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/smbpec_crc.sv
// CRC-8 over the five bytes of an SMBus read-word transaction.
module smbpec_crc
    import smbpec_pkg::*;
(
    input  logic [AddrW-1:0] i_dev_addr,
    input  logic [ByteW-1:0] i_register_address,
    input  logic [ByteW-1:0] i_data_low,
    input  logic [ByteW-1:0] i_data_high,
    output logic [ByteW-1:0] o_crc
);

    logic [ByteW-1:0] w_wr_addr;
    logic [ByteW-1:0] w_rd_addr;
    logic [ByteW-1:0] w_c0;
    logic [ByteW-1:0] w_c1;
    logic [ByteW-1:0] w_c2;
    logic [ByteW-1:0] w_c3;

    assign w_wr_addr = {i_dev_addr, 1'b0};
    assign w_rd_addr = {i_dev_addr, 1'b1};

    assign w_c0  = crc8_byte(CrcInit, w_wr_addr);
    assign w_c1  = crc8_byte(w_c0, i_register_address);
    assign w_c2  = crc8_byte(w_c1, w_rd_addr);
    assign w_c3  = crc8_byte(w_c2, i_data_low);
    assign o_crc = crc8_byte(w_c3, i_data_high);

endmodule

FILE: rtl/smbus_pec_temperature_reader_top.sv
// SMBus PEC-checked temperature reader: input register, PEC check and retry state, result register.
// Transactions pass from the input register to the result register. Throughput: one transaction per
// cycle while the output is not stalled; the PEC check and counter update sit between the two
// registers, and the retry and failure state advances as each transaction enters the result register.
// Reset: synchronous, active low; clears both valid flags, the attempt and failure counters and the
// error latch, and loads device address 0x5A, retry limit 3 and error threshold 5.
module smbus_pec_temperature_reader_top
    import smbpec_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CfgIdxW-1:0]      i_cfg_index,
    input  logic [CountW-1:0]       i_cfg_wdata,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [ByteW-1:0]        i_register_address,
    input  logic                    i_bus_ok,
    input  logic [ByteW-1:0]        i_data_low,
    input  logic [ByteW-1:0]        i_data_high,
    input  logic [ByteW-1:0]        i_pec_byte,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_attempt_ok,
    output logic                    o_read_done,
    output logic                    o_read_ok,
    output logic [WordW-1:0]        o_raw_word,
    output logic signed [TempW-1:0] o_temperature_centi,
    output logic                    o_device_error,
    output logic [CountW-1:0]       o_failures
);

    logic [AddrW-1:0]  r_dev_addr;
    logic [RetryW-1:0] r_retry_limit;
    logic [CountW-1:0] r_threshold;

    logic              r_in_valid;
    logic [ByteW-1:0]  r_reg_addr;
    logic              r_bus_ok;
    logic [ByteW-1:0]  r_data_low;
    logic [ByteW-1:0]  r_data_high;
    logic [ByteW-1:0]  r_pec;

    logic [RetryW-1:0] r_attempts;
    logic [CountW-1:0] r_fail_cnt;
    logic              r_err_latched;
    logic [RetryW-1:0] n_attempts;
    logic [CountW-1:0] n_fail_cnt;
    logic              n_err_latched;

    logic                    r_out_valid;
    logic                    r_attempt_ok;
    logic                    r_read_done;
    logic [WordW-1:0]        r_raw_word;
    logic signed [TempW-1:0] r_temp;
    logic                    n_read_done;
    logic [WordW-1:0]        n_raw_word;
    logic signed [TempW-1:0] n_temp;

    logic              w_out_load;
    logic              w_adv;
    logic              w_in_take;
    logic [ByteW-1:0]  w_crc;
    logic              w_ok;
    logic [RetryW-1:0] w_limit;
    logic [RetryW-1:0] w_att_inc;
    logic [CountW-1:0] w_fail_inc;

    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_in_stall = r_in_valid && !w_out_load;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= RstDevAddr;
            r_retry_limit <= RstRetry;
            r_threshold   <= RstThreshold;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgDevAddr:   r_dev_addr    <= i_cfg_wdata[AddrW-1:0];
                CfgRetry:     r_retry_limit <= i_cfg_wdata[RetryW-1:0];
                CfgThreshold: r_threshold   <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_reg_addr  <= i_register_address;
            r_bus_ok    <= i_bus_ok;
            r_data_low  <= i_data_low;
            r_data_high <= i_data_high;
            r_pec       <= i_pec_byte;
        end
    end

    smbpec_crc u_crc (
        .i_dev_addr         (r_dev_addr),
        .i_register_address (r_reg_addr),
        .i_data_low         (r_data_low),
        .i_data_high        (r_data_high),
        .o_crc              (w_crc)
    );

    assign w_ok       = r_bus_ok && (w_crc == r_pec);
    assign w_limit    = (r_retry_limit == '0) ? RetryW'(1) : r_retry_limit;
    assign w_att_inc  = r_attempts + RetryW'(1);
    assign w_fail_inc = (r_fail_cnt == FailSat) ? r_fail_cnt
                                                : r_fail_cnt + CountW'(1);

    always_comb begin
        n_attempts    = r_attempts;
        n_fail_cnt    = r_fail_cnt;
        n_err_latched = r_err_latched;
        n_read_done   = 1'b0;
        n_raw_word    = '0;
        n_temp        = '0;
        priority if (w_ok) begin
            n_read_done   = 1'b1;
            n_raw_word    = {r_data_high, r_data_low};
            n_temp        = $signed({1'b0, r_data_high, r_data_low, 1'b0}) - TempOffset;
            n_attempts    = '0;
            n_fail_cnt    = '0;
            n_err_latched = 1'b0;
        end else if (w_att_inc >= w_limit) begin
            n_read_done   = 1'b1;
            n_attempts    = '0;
            n_fail_cnt    = w_fail_inc;
            n_err_latched = r_err_latched || (w_fail_inc >= r_threshold);
        end else begin
            n_attempts    = w_att_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempts    <= '0;
            r_fail_cnt    <= '0;
            r_err_latched <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_attempts    <= n_attempts;
                r_fail_cnt    <= n_fail_cnt;
                r_err_latched <= n_err_latched;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_attempt_ok <= w_ok;
            r_read_done  <= n_read_done;
            r_raw_word   <= n_raw_word;
            r_temp       <= n_temp;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_attempt_ok        = r_attempt_ok;
    assign o_read_done         = r_read_done;
    assign o_read_ok           = r_attempt_ok;
    assign o_raw_word          = r_raw_word;
    assign o_temperature_centi = r_temp;
    assign o_device_error      = r_err_latched;
    assign o_failures          = r_fail_cnt;

    a_attempts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attempts != RetryW'(7))
        else $error("attempt counter reached an impossible value");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_attempt_ok) |-> (r_fail_cnt == '0 && !r_err_latched))
        else $error("successful read left failures or error latch set");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_attempt_ok) |-> (r_raw_word == '0 && r_temp == '0))
        else $error("failed attempt carries nonzero data");

    a_latch_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_err_latched) |-> ($past(w_adv) && r_read_done && !r_attempt_ok))
        else $error("error latch set without a failed read");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_load) |=> r_in_valid)
        else $error("pending transaction dropped while output stalled");

endmodule
